### design/jcsm_pkg.sv
// jcsm_pkg: shared widths, codes and beat types of the joystick calibration core
// no dependencies; used by joystick_calibrate_servo_map_core
package jcsm_pkg;

	localparam int SAMPLE_W = 10;
	localparam int SPAN_W   = 12;
	localparam int PHASE_W  = 3;
	localparam int OP_W     = 2;
	localparam int PROD_W   = SPAN_W + SAMPLE_W;
	localparam int CNT_W    = $clog2(PROD_W);

	localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(480);

	localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic [PHASE_W-1:0] PH_MAX_X   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_MIN_X   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_MAX_Y   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_MIN_Y   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SERVO_X = 3'd4;
	localparam logic [PHASE_W-1:0] PH_SERVO_Y = 3'd5;
	localparam logic [PHASE_W-1:0] PH_DONE    = 3'd6;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [SAMPLE_W-1:0] x_sample;
		logic [SAMPLE_W-1:0] y_sample;
	} in_beat_t;

	typedef struct packed {
		logic [PHASE_W-1:0]  phase;
		logic                all_done;
		logic [SPAN_W-1:0]   x_pulse;
		logic [SPAN_W-1:0]   y_pulse;
		logic [SAMPLE_W-1:0] x_low;
		logic [SAMPLE_W-1:0] x_high;
		logic [SAMPLE_W-1:0] y_low;
		logic [SAMPLE_W-1:0] y_high;
	} out_beat_t;

endpackage

### design/joystick_calibrate_servo_map_core.sv
// joystick_calibrate_servo_map_core: calibration sequencer with bit-serial servo scaling
// depends on jcsm_pkg (widths, op and phase codes, beat structs)
//
// Every input beat gives exactly one output beat showing the state after that beat.
// Advance, restart, measure samples, ignored samples and servo samples with an empty
// range go from accept straight to report. A servo sample is accepted and clamped, then
// passes a shift-and-add multiplier (one bit of the clamped offset per cycle) and a
// restoring divider (one quotient bit per cycle), then loads the output register. The
// output register lets the next beat be accepted while a result waits. The user must
// write pulse_span through cfg_we/cfg_data while the core is idle; it is not enforced.

module joystick_calibrate_servo_map_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  jcsm_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output jcsm_pkg::out_beat_t                 out_data,
	input  logic                                cfg_we,
	input  logic [jcsm_pkg::SPAN_W-1:0]         cfg_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MUL    = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_REPORT = 2'd3;

	logic [1:0]                        state_q;
	logic [jcsm_pkg::CNT_W-1:0]        cnt_q;
	logic                              sel_y_q;
	logic [jcsm_pkg::SPAN_W-1:0]       span_q;
	logic [jcsm_pkg::PHASE_W-1:0]      phase_q;
	logic [jcsm_pkg::SAMPLE_W-1:0]     x_min_q, x_max_q, y_min_q, y_max_q;
	logic [jcsm_pkg::SPAN_W-1:0]       x_pulse_q, y_pulse_q;
	logic [jcsm_pkg::SAMPLE_W-1:0]     diff_q;
	logic [jcsm_pkg::SAMPLE_W-1:0]     den_q;
	logic [jcsm_pkg::SAMPLE_W-1:0]     rem_q;
	logic [jcsm_pkg::PROD_W-1:0]       acc_q;
	logic [jcsm_pkg::SPAN_W-1:0]       quo_q;
	logic                              out_valid_q;
	jcsm_pkg::out_beat_t               out_q;

	logic                              in_accept;
	logic                              out_free;
	logic                              servo_y;
	logic                              start_mul;
	logic [jcsm_pkg::SAMPLE_W-1:0]     v, lo, hi, vc;
	logic [jcsm_pkg::SAMPLE_W:0]       rem_sh;
	logic [jcsm_pkg::SAMPLE_W+1:0]     trial;
	logic                              q_bit;
	logic [jcsm_pkg::SAMPLE_W-1:0]     rem_next;
	logic [jcsm_pkg::SPAN_W-1:0]       quo_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// clamp the sample into the learned range of the servo axis
	always_comb begin
		servo_y = (phase_q == jcsm_pkg::PH_SERVO_Y);
		v  = servo_y ? in_data.y_sample : in_data.x_sample;
		lo = servo_y ? y_min_q : x_min_q;
		hi = servo_y ? y_max_q : x_max_q;
		if (v < lo) begin
			vc = lo;
		end else if (v > hi) begin
			vc = hi;
		end else begin
			vc = v;
		end
	end

	// servo sample with a non-empty range goes through the multiplier
	assign start_mul = (in_data.op == jcsm_pkg::OP_SAMPLE)
		&& (phase_q == jcsm_pkg::PH_SERVO_X || phase_q == jcsm_pkg::PH_SERVO_Y)
		&& (hi > lo);

	// one restoring divide step
	always_comb begin
		rem_sh   = {rem_q, acc_q[jcsm_pkg::PROD_W-1]};
		trial    = {1'b0, rem_sh} - {2'b00, den_q};
		q_bit    = !trial[jcsm_pkg::SAMPLE_W+1];
		rem_next = q_bit ? trial[jcsm_pkg::SAMPLE_W-1:0] : rem_sh[jcsm_pkg::SAMPLE_W-1:0];
		quo_next = {quo_q[jcsm_pkg::SPAN_W-2:0], q_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_y_q     <= 1'b0;
			span_q      <= jcsm_pkg::SPAN_RESET;
			phase_q     <= jcsm_pkg::PH_MAX_X;
			x_min_q     <= '1;
			x_max_q     <= '0;
			y_min_q     <= '1;
			y_max_q     <= '0;
			x_pulse_q   <= '0;
			y_pulse_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				span_q <= cfg_data;
			end
			if (state_q == ST_REPORT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= start_mul ? ST_MUL : ST_REPORT;
						unique case (in_data.op)
							jcsm_pkg::OP_ADVANCE: begin
								if (phase_q != jcsm_pkg::PH_DONE) begin
									phase_q <= phase_q + 3'd1;
								end
							end
							jcsm_pkg::OP_RESTART: begin
								phase_q <= jcsm_pkg::PH_MAX_X;
								x_min_q <= '1;
								x_max_q <= '0;
								y_min_q <= '1;
								y_max_q <= '0;
							end
							jcsm_pkg::OP_SAMPLE: begin
								unique case (phase_q)
									jcsm_pkg::PH_MAX_X: begin
										if (in_data.x_sample > x_max_q) begin
											x_max_q <= in_data.x_sample;
										end
									end
									jcsm_pkg::PH_MIN_X: begin
										if (in_data.x_sample < x_min_q) begin
											x_min_q <= in_data.x_sample;
										end
									end
									jcsm_pkg::PH_MAX_Y: begin
										if (in_data.y_sample > y_max_q) begin
											y_max_q <= in_data.y_sample;
										end
									end
									jcsm_pkg::PH_MIN_Y: begin
										if (in_data.y_sample < y_min_q) begin
											y_min_q <= in_data.y_sample;
										end
									end
									jcsm_pkg::PH_SERVO_X, jcsm_pkg::PH_SERVO_Y: begin
										sel_y_q <= servo_y;
										if (hi <= lo) begin
											if (servo_y) begin
												y_pulse_q <= '0;
											end else begin
												x_pulse_q <= '0;
											end
										end else begin
											cnt_q   <= '0;
											diff_q  <= vc - lo;
											den_q   <= hi - lo;
											acc_q   <= '0;
										end
									end
									default: begin
									end
								endcase
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					// product built msb first, one offset bit per cycle
					acc_q  <= {acc_q[jcsm_pkg::PROD_W-2:0], 1'b0}
						+ (diff_q[jcsm_pkg::SAMPLE_W-1] ? jcsm_pkg::PROD_W'(span_q) : '0);
					diff_q <= {diff_q[jcsm_pkg::SAMPLE_W-2:0], 1'b0};
					if (cnt_q == jcsm_pkg::CNT_W'(jcsm_pkg::SAMPLE_W - 1)) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						rem_q   <= '0;
						quo_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					acc_q <= {acc_q[jcsm_pkg::PROD_W-2:0], 1'b0};
					if (cnt_q == jcsm_pkg::CNT_W'(jcsm_pkg::PROD_W - 1)) begin
						state_q <= ST_REPORT;
						if (sel_y_q) begin
							y_pulse_q <= quo_next;
						end else begin
							x_pulse_q <= quo_next;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (state_q == ST_REPORT && out_free) begin
			out_q.phase    <= phase_q;
			out_q.all_done <= (phase_q == jcsm_pkg::PH_DONE);
			out_q.x_pulse  <= x_pulse_q;
			out_q.y_pulse  <= y_pulse_q;
			out_q.x_low    <= x_min_q;
			out_q.x_high   <= x_max_q;
			out_q.y_low    <= y_min_q;
			out_q.y_high   <= y_max_q;
		end
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= jcsm_pkg::PH_DONE)
		else $error("phase past done");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start work");

	a_out_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_REPORT))
		else $error("output beat not from report");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

	a_done_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.all_done == (out_q.phase == jcsm_pkg::PH_DONE)))
		else $error("all_done mismatch");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for joystick_calibrate_servo_map_core, with a clocked driver,
// a clocked monitor and an in-bench calibration predictor fed at every accepted beat
// depends on jcsm_pkg and the core only

module tb;

	localparam logic [jcsm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int RUN_ITEMS   = 170;

	typedef enum int {REST_NONE, REST_SENDER, REST_RECEIVER, REST_BOTH} rest_mode_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	jcsm_pkg::in_beat_t            in_data   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	jcsm_pkg::out_beat_t           out_data;
	logic                          cfg_we    = 1'b0;
	logic [jcsm_pkg::SPAN_W-1:0]   cfg_data  = '0;

	jcsm_pkg::in_beat_t            beat_queue[$];
	jcsm_pkg::out_beat_t           predicted_status[$];
	rest_mode_t                    rest_mode = REST_NONE;
	bit                            pressure_on = 1'b0;
	bit                            hold_used;
	int                            hold_left;
	int                            quiet_cycles = 0;
	int                            mismatches = 0;
	int                            queued_items = 0;

	// predictor state
	logic [jcsm_pkg::SPAN_W-1:0]   span_now = jcsm_pkg::SPAN_RESET;
	logic [jcsm_pkg::PHASE_W-1:0]  cur_phase;
	logic [jcsm_pkg::SAMPLE_W-1:0] x_lo, x_hi, y_lo, y_hi;
	logic [jcsm_pkg::SPAN_W-1:0]   x_duty, y_duty;

	joystick_calibrate_servo_map_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [jcsm_pkg::SPAN_W-1:0] scaled_duty(
			input logic [jcsm_pkg::SAMPLE_W-1:0] v,
			input logic [jcsm_pkg::SAMPLE_W-1:0] lo,
			input logic [jcsm_pkg::SAMPLE_W-1:0] hi);
		logic [jcsm_pkg::SAMPLE_W-1:0] c;
		int unsigned num;
		int unsigned den;
		if (hi <= lo)
			return '0;
		c = (v < lo) ? lo : ((v > hi) ? hi : v);
		num = span_now;
		num = num * (c - lo);
		den = hi - lo;
		return jcsm_pkg::SPAN_W'(num / den);
	endfunction

	task automatic clear_extremes();
		cur_phase = jcsm_pkg::PH_MAX_X;
		x_lo = '1;
		x_hi = '0;
		y_lo = '1;
		y_hi = '0;
	endtask

	task automatic advance_calibration(input jcsm_pkg::in_beat_t b);
		jcsm_pkg::out_beat_t r;
		case (b.op)
			jcsm_pkg::OP_ADVANCE: begin
				if (cur_phase < jcsm_pkg::PH_DONE)
					cur_phase = cur_phase + 1'b1;
			end
			jcsm_pkg::OP_RESTART: clear_extremes();
			jcsm_pkg::OP_SAMPLE: begin
				case (cur_phase)
					jcsm_pkg::PH_MAX_X:   if (b.x_sample > x_hi) x_hi = b.x_sample;
					jcsm_pkg::PH_MIN_X:   if (b.x_sample < x_lo) x_lo = b.x_sample;
					jcsm_pkg::PH_MAX_Y:   if (b.y_sample > y_hi) y_hi = b.y_sample;
					jcsm_pkg::PH_MIN_Y:   if (b.y_sample < y_lo) y_lo = b.y_sample;
					jcsm_pkg::PH_SERVO_X: x_duty = scaled_duty(b.x_sample, x_lo, x_hi);
					jcsm_pkg::PH_SERVO_Y: y_duty = scaled_duty(b.y_sample, y_lo, y_hi);
					default: ;
				endcase
			end
			default: ;
		endcase
		r.phase    = cur_phase;
		r.all_done = (cur_phase == jcsm_pkg::PH_DONE);
		r.x_pulse  = x_duty;
		r.y_pulse  = y_duty;
		r.x_low    = x_lo;
		r.x_high   = x_hi;
		r.y_low    = y_lo;
		r.y_high   = y_hi;
		predicted_status.push_back(r);
	endtask

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic bit sender_rests();
		case (rest_mode)
			REST_SENDER: return $urandom_range(99) < 70;
			REST_BOTH:   return $urandom_range(99) < 10;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_rests();
		case (rest_mode)
			REST_RECEIVER: return $urandom_range(99) < 70;
			REST_BOTH:     return $urandom_range(99) < 10;
			default:       return 1'b0;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall)
				advance_calibration(in_data);
			if (!in_valid || !in_stall) begin
				if (beat_queue.size() != 0 && !sender_rests()) begin
					in_data  <= beat_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, including the one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (pressure_on && !hold_used) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else begin
			out_stall <= receiver_rests();
		end
	end

	// monitor
	always @(posedge clk) begin
		jcsm_pkg::out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_status.size() == 0) begin
				note_mismatch("beat with nothing predicted", out_data.phase, 0);
			end else begin
				want = predicted_status.pop_front();
				if (out_data.phase !== want.phase)
					note_mismatch("phase", out_data.phase, want.phase);
				if (out_data.all_done !== want.all_done)
					note_mismatch("all_done", out_data.all_done, want.all_done);
				if (out_data.x_pulse !== want.x_pulse)
					note_mismatch("x_pulse", out_data.x_pulse, want.x_pulse);
				if (out_data.y_pulse !== want.y_pulse)
					note_mismatch("y_pulse", out_data.y_pulse, want.y_pulse);
				if (out_data.x_low !== want.x_low)
					note_mismatch("x_low", out_data.x_low, want.x_low);
				if (out_data.x_high !== want.x_high)
					note_mismatch("x_high", out_data.x_high, want.x_high);
				if (out_data.y_low !== want.y_low)
					note_mismatch("y_low", out_data.y_low, want.y_low);
				if (out_data.y_high !== want.y_high)
					note_mismatch("y_high", out_data.y_high, want.y_high);
			end
		end
	end

	// watchdog on cycles without any beat moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [jcsm_pkg::SAMPLE_W-1:0] any_sample();
		return jcsm_pkg::SAMPLE_W'($urandom_range(1023));
	endfunction

	task automatic push_beat(input logic [jcsm_pkg::OP_W-1:0] op,
			input logic [jcsm_pkg::SAMPLE_W-1:0] x,
			input logic [jcsm_pkg::SAMPLE_W-1:0] y);
		jcsm_pkg::in_beat_t b;
		b.op = op;
		b.x_sample = x;
		b.y_sample = y;
		beat_queue.push_back(b);
		if (op != OP_UNUSED)
			queued_items++;
	endtask

	task automatic maybe_noise();
		if ($urandom_range(11) == 0)
			push_beat(jcsm_pkg::OP_W'($urandom_range(3)), any_sample(), any_sample());
	endtask

	// restart, learn both ranges, drive both servos, sometimes poke at done
	task automatic queue_sequence();
		int p;
		int i;
		int n;
		bit tight;
		logic [jcsm_pkg::SAMPLE_W-1:0] c;
		tight = ($urandom_range(3) == 0);
		c = any_sample();
		push_beat(jcsm_pkg::OP_RESTART, any_sample(), any_sample());
		for (p = 0; p < 4; p++) begin
			n = $urandom_range(4);
			for (i = 0; i < n; i++) begin
				if (tight)
					push_beat(jcsm_pkg::OP_SAMPLE,
						c ^ jcsm_pkg::SAMPLE_W'($urandom_range(1)),
						c ^ jcsm_pkg::SAMPLE_W'($urandom_range(1)));
				else
					push_beat(jcsm_pkg::OP_SAMPLE, any_sample(), any_sample());
				maybe_noise();
			end
			push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		end
		for (p = 0; p < 2; p++) begin
			n = $urandom_range(8, 1);
			for (i = 0; i < n; i++) begin
				push_beat(jcsm_pkg::OP_SAMPLE, any_sample(), any_sample());
				maybe_noise();
			end
			push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		end
		if ($urandom_range(3) == 0) begin
			push_beat(jcsm_pkg::OP_SAMPLE, any_sample(), any_sample());
			push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		end
	endtask

	task automatic set_span(input logic [jcsm_pkg::SPAN_W-1:0] v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		span_now = v;
		@(negedge clk);
	endtask

	task automatic drain();
		while (beat_queue.size() != 0 || in_valid || predicted_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_run(input logic [jcsm_pkg::SPAN_W-1:0] span,
			input rest_mode_t mode, input bit squeeze);
		int start;
		drain();
		set_span(span);
		rest_mode   = mode;
		pressure_on = squeeze;
		start = queued_items;
		while (queued_items - start < RUN_ITEMS)
			queue_sequence();
	endtask

	initial begin
		clear_extremes();
		x_duty = '0;
		y_duty = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: full walk at the reset span, clamping, done handling, empty range
		push_beat(OP_UNUSED, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd600, 10'd1023);
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd200, 10'd0);
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd0, 10'd1000);
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd1023, 10'd0);
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd0, 10'd1023);
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd1023, 10'd0);
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd400, 10'd555);
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd0, 10'd1023);
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd1023, 10'd77);
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_SAMPLE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(OP_UNUSED, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_RESTART, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_ADVANCE, any_sample(), any_sample());
		push_beat(jcsm_pkg::OP_SAMPLE, 10'd512, 10'd512);

		random_run(jcsm_pkg::SPAN_W'(4095), REST_NONE, 1'b0);
		random_run(jcsm_pkg::SPAN_W'(0), REST_SENDER, 1'b0);
		random_run(jcsm_pkg::SPAN_W'(1), REST_RECEIVER, 1'b0);
		random_run(jcsm_pkg::SPAN_W'($urandom_range(4095)), REST_BOTH, 1'b0);
		random_run(jcsm_pkg::SPAN_RESET, REST_NONE, 1'b1);
		random_run(jcsm_pkg::SPAN_W'($urandom_range(4095)), REST_SENDER, 1'b0);

		drain();
		repeat (60) @(negedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
